// File: hw/rtl/bfbp_pkg.sv
package bfbp_pkg;

  // field widths fixed by the interface
  localparam int unsigned WeightW    = 16;
  localparam int unsigned CapW       = 16;
  localparam int unsigned PreclosedW = 10;
  localparam int unsigned BinW       = 9;
  localparam int unsigned TotalW     = 11;
  localparam int unsigned StatusW    = 2;

  // default bin table depth
  localparam int unsigned MaxBinsDef = 256;

  // configuration port
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;
  localparam logic [15:0] CapacityRst = 16'd100;

  typedef enum logic [0:0] {
    REG_CAPACITY  = 1'b0,
    REG_PRECLOSED = 1'b1
  } reg_idx_e;

  typedef enum logic [StatusW-1:0] {
    ST_PLACED     = 2'd0,
    ST_SKIPPED    = 2'd1,
    ST_OVER_CAP   = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_UPDATE = 2'd2,
    S_DONE   = 2'd3
  } state_e;

  typedef struct packed {
    logic [WeightW-1:0] weight;
    logic               first_item;
  } in_item_t;

  typedef struct packed {
    logic [BinW-1:0]    bin_number;
    logic               opened_new;
    logic [TotalW-1:0]  total_bins;
    logic [StatusW-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic update;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic place_in;
    logic all_issued;
  } dp_status_t;

endpackage

// File: hw/rtl/bfbp_ram.sv
module bfbp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/bfbp_ctrl.sv
module bfbp_ctrl import bfbp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t dp_status_i,
  output dp_cmd_t    dp_cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = dp_status_i.place_in ? S_SCAN : S_UPDATE;
        end
      end
      S_SCAN: begin
        if (dp_status_i.all_issued) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    dp_cmd_o   = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o      = 1'b1;
        dp_cmd_o.accept = in_valid_i;
      end
      S_SCAN: begin
        dp_cmd_o.scan = 1'b1;
      end
      S_UPDATE: begin
        dp_cmd_o.update = 1'b1;
      end
      S_DONE: begin
        dp_cmd_o.load = out_free;
      end
      default: begin
        dp_cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (dp_cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // one item in flight at a time
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while another is in flight");

endmodule

// File: hw/rtl/bfbp_datapath.sv
module bfbp_datapath import bfbp_pkg::*; #(
  parameter int unsigned MaxBins = MaxBinsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [CapW-1:0]       cfg_capacity_i,
  input  logic [PreclosedW-1:0] cfg_preclosed_i,
  input  in_item_t              in_data_i,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  output out_item_t             out_data_o
);

  localparam int unsigned IdxW    = $clog2(MaxBins);
  localparam int unsigned CntW    = $clog2(MaxBins + 1);
  localparam int unsigned SumW    = ((CntW > PreclosedW) ? CntW : PreclosedW) + 1;
  localparam int unsigned BinExtW = ((IdxW + 1) > BinW) ? (IdxW + 1) : BinW;

  // control state
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    scan_cnt_q, scan_cnt_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic               found_q, found_d;

  // payload
  logic [WeightW-1:0] weight_q, weight_d;
  status_e            kind_q, kind_d;
  logic [IdxW-1:0]    cmp_idx_q;
  logic [CapW-1:0]    best_left_q, best_left_d;
  logic [IdxW-1:0]    best_idx_q, best_idx_d;
  out_item_t          res_q, res_d;
  out_item_t          out_q;

  // residual store
  logic               ram_we;
  logic [IdxW-1:0]    ram_waddr;
  logic [CapW-1:0]    ram_wdata;
  logic [CapW-1:0]    ram_rdata;

  logic               all_issued;
  logic [CapW-1:0]    left;
  logic               better;
  logic               place_ok;
  logic               table_full;
  logic               open_new;
  logic [CntW-1:0]    count_next;
  logic [SumW-1:0]    total_sum;
  logic [BinExtW-1:0] bin_ext;

  bfbp_ram #(
    .Width (CapW),
    .Depth (MaxBins)
  ) u_residual_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (scan_cnt_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign all_issued          = (scan_cnt_q == count_q);
  assign status_o.all_issued = all_issued;
  assign status_o.place_in   = (in_data_i.weight != '0) &&
                               (in_data_i.weight <= cfg_capacity_i);

  // compare stage on the registered read
  assign left   = ram_rdata - weight_q;
  assign better = cmp_vld_q && (ram_rdata >= weight_q) &&
                  (!found_q || (left < best_left_q));

  // update decision
  assign place_ok   = (kind_q == ST_PLACED);
  assign table_full = (count_q == CntW'(MaxBins));
  assign open_new   = place_ok && !found_q && !table_full;
  assign count_next = count_q + CntW'(open_new);
  assign ram_we     = cmd_i.update && place_ok && (found_q || !table_full);
  assign ram_waddr  = found_q ? best_idx_q : count_q[IdxW-1:0];
  assign ram_wdata  = found_q ? best_left_q : (cfg_capacity_i - weight_q);
  assign total_sum  = SumW'(count_next) + SumW'(cfg_preclosed_i);

  always_comb begin
    bin_ext = '0;
    if (place_ok && found_q) begin
      bin_ext = BinExtW'(best_idx_q) + BinExtW'(1);
    end else if (open_new) begin
      bin_ext = BinExtW'(count_q[IdxW-1:0]) + BinExtW'(1);
    end
  end

  always_comb begin
    res_d            = res_q;
    res_d.bin_number = bin_ext[BinW-1:0];
    res_d.opened_new = open_new;
    res_d.total_bins = total_sum[TotalW-1:0];
    res_d.status     = (place_ok && !found_q && table_full) ? ST_TABLE_FULL : kind_q;
  end

  always_comb begin
    count_d     = count_q;
    scan_cnt_d  = scan_cnt_q;
    found_d     = found_q;
    weight_d    = weight_q;
    kind_d      = kind_q;
    best_left_d = best_left_q;
    best_idx_d  = best_idx_q;
    cmp_vld_d   = cmd_i.scan && !all_issued;

    if (cmd_i.accept) begin
      weight_d   = in_data_i.weight;
      scan_cnt_d = '0;
      found_d    = 1'b0;
      if (in_data_i.first_item) begin
        count_d = '0;
      end
      if (in_data_i.weight == '0) begin
        kind_d = ST_SKIPPED;
      end else if (in_data_i.weight > cfg_capacity_i) begin
        kind_d = ST_OVER_CAP;
      end else begin
        kind_d = ST_PLACED;
      end
    end

    if (cmd_i.scan && !all_issued) begin
      scan_cnt_d = scan_cnt_q + CntW'(1);
    end

    if (better) begin
      found_d     = 1'b1;
      best_left_d = left;
      best_idx_d  = cmp_idx_q;
    end

    if (cmd_i.update) begin
      count_d = count_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      scan_cnt_q <= '0;
      cmp_vld_q  <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      count_q    <= count_d;
      scan_cnt_q <= scan_cnt_d;
      cmp_vld_q  <= cmp_vld_d;
      found_q    <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    weight_q    <= weight_d;
    kind_q      <= kind_d;
    cmp_idx_q   <= scan_cnt_q[IdxW-1:0];
    best_left_q <= best_left_d;
    best_idx_q  <= best_idx_d;
    if (cmd_i.update) begin
      res_q <= res_d;
    end
    if (cmd_i.load) begin
      out_q <= res_q;
    end
  end

  assign out_data_o = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxBins))
    else $error("open bin count beyond table depth");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> scan_cnt_q <= count_q)
    else $error("scan ran past the open bins");

  a_best_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update && found_q |-> CntW'(best_idx_q) < count_q)
    else $error("best fit points at a bin that is not open");

endmodule

// File: hw/rtl/best_fit_bin_packer_unit.sv
// best-fit bin packer: each accepted item carries a weight and a first_item
// flag; the block places it into the open bin with the least space left
// over (lowest bin on a tie) or opens a new bin, and returns one result item
// with the 1-based bin number, a new-bin flag, the running bin total
// (open bins plus preclosed_bins, 11 bits) and a status code. first_item
// closes all open bins before the weight is handled. zero weights, weights
// above capacity and a full table give a status but change no bin.
// one item is worked on at a time; for a weight that can be placed the
// result register is loaded after one read of the residual RAM per open
// bin, one settle step, one update and the load; skipped and rejected
// weights go through the update and the load only. the next item can be
// taken in the cycle after the load. the single residual RAM read port sets
// the scan length. a finished result may wait in the output register while
// the next item is accepted; the load waits only while that register still
// holds an unread result.
// configuration over APB: capacity at 0x0, preclosed_bins at 0x4; write
// only while no item is in flight. no clearing pass is needed after reset.
module best_fit_bin_packer_unit import bfbp_pkg::*; #(
  parameter int unsigned MAX_BINS = MaxBinsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  // item input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,

  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,

  // APB configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  // configuration registers
  logic [CapW-1:0]       capacity_q, capacity_d;
  logic [PreclosedW-1:0] preclosed_q, preclosed_d;
  logic                  cfg_write;
  reg_idx_e              reg_idx;

  dp_cmd_t               dp_cmd;
  dp_status_t            dp_status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  // word address picks the register, byte lanes are ignored
  assign reg_idx   = reg_idx_e'(paddr[2]);

  always_comb begin
    capacity_d  = capacity_q;
    preclosed_d = preclosed_q;
    if (cfg_write) begin
      case (reg_idx)
        REG_CAPACITY: begin
          capacity_d = pwdata[CapW-1:0];
        end
        REG_PRECLOSED: begin
          preclosed_d = pwdata[PreclosedW-1:0];
        end
        default: begin
          capacity_d = capacity_q;
        end
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_CAPACITY: begin
        prdata = ApbDataW'(capacity_q);
      end
      REG_PRECLOSED: begin
        prdata = ApbDataW'(preclosed_q);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= CapacityRst;
      preclosed_q <= '0;
    end else begin
      capacity_q  <= capacity_d;
      preclosed_q <= preclosed_d;
    end
  end

  // sequencer: accept, scan the open bins, update, hand over the result
  bfbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dp_status_i (dp_status),
    .dp_cmd_o    (dp_cmd)
  );

  // residual RAM, best-fit compare and result assembly
  bfbp_datapath #(
    .MaxBins (MAX_BINS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_capacity_i  (capacity_q),
    .cfg_preclosed_i (preclosed_q),
    .in_data_i       (in_data_i),
    .cmd_i           (dp_cmd),
    .status_o        (dp_status),
    .out_data_o      (out_data_o)
  );

endmodule

// File: dv/tb_best_fit_bin_packer_unit.sv
module tb_best_fit_bin_packer_unit;
  import bfbp_pkg::*;

  localparam int unsigned MaxBins    = MaxBinsDef;
  localparam int unsigned ItemTarget = 1150;
  // longest correct quiet stretch is a full scan plus a receiver stall
  localparam int unsigned StallLimit = 4000;

  // one row of the directed walk: the item, and a hand-written result where one is given
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } directed_row_t;

  localparam int unsigned NumDirected = 20;
  localparam out_item_t   Untyped     = '0;

  // receiver back-pressure styles
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_LONG_STALL
  } rx_mode_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_data_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [ApbAddrW-1:0] paddr       = '0;
  logic [ApbDataW-1:0] pwdata      = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // shadow of the block: residual space per open bin and the live settings
  logic [CapW-1:0]       bin_space [MaxBins];
  int unsigned           bins_open     = 0;
  logic [CapW-1:0]       cap_reg       = CapacityRst;
  logic [PreclosedW-1:0] preclosed_reg = '0;

  // results still owed by the block, oldest first
  out_item_t pending_placements [$];

  directed_row_t directed_rows [NumDirected];

  int unsigned mismatches    = 0;
  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned setting_count = 0;
  int unsigned status_seen [4] = '{default: 0};
  int unsigned quiet_cycles  = 0;

  // sender pacing
  logic        steady_feed = 1'b0;
  int unsigned burst_left  = 0;

  // receiver pacing
  rx_mode_e    rx_mode      = RX_OPEN;
  int unsigned rx_mode_left = 0;
  int unsigned rx_hold      = 0;
  int unsigned rx_tick      = 0;

  best_fit_bin_packer_unit #(
    .MAX_BINS (MaxBins)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  // best-fit placement of one item against the shadow bins
  function automatic out_item_t place_best_fit(input in_item_t it);
    out_item_t       res;
    logic            found;
    logic [CapW-1:0] best_left;
    int unsigned     best_idx;
    int unsigned     j;
    res       = '0;
    found     = 1'b0;
    best_left = '0;
    best_idx  = 0;
    // the clear comes first, even when the weight is then skipped or rejected
    if (it.first_item) bins_open = 0;
    if (it.weight == '0) begin
      res.status = ST_SKIPPED;
    end else if (it.weight > cap_reg) begin
      res.status = ST_OVER_CAP;
    end else begin
      // least leftover wins, strict compare keeps the lowest bin on a tie
      for (j = 0; j < bins_open; j++) begin
        if (bin_space[j] >= it.weight &&
            (!found || bin_space[j] - it.weight < best_left)) begin
          found     = 1'b1;
          best_left = bin_space[j] - it.weight;
          best_idx  = j;
        end
      end
      if (found) begin
        bin_space[best_idx] = best_left;
        res.bin_number      = BinW'(best_idx + 1);
      end else if (bins_open >= MaxBins) begin
        res.status = ST_TABLE_FULL;
      end else begin
        bin_space[bins_open] = cap_reg - it.weight;
        bins_open++;
        res.bin_number = BinW'(bins_open);
        res.opened_new = 1'b1;
      end
    end
    res.total_bins = TotalW'(bins_open + preclosed_reg);
    return res;
  endfunction

  // weights spread over skips, over-capacity, exact fills, unit weights,
  // repeated fractions of the capacity (ties) and uniform picks
  function automatic logic [WeightW-1:0] pick_weight();
    int unsigned sel;
    int unsigned cap;
    sel = $urandom_range(99);
    cap = cap_reg;
    if (sel < 3) return '0;
    if (sel < 6) return (cap == 65535) ? WeightW'(cap) : WeightW'($urandom_range(65535, cap + 1));
    if (sel < 11) return WeightW'(cap);
    if (sel < 16) return WeightW'(1);
    if (sel < 46) return WeightW'(cap / $urandom_range(6, 2) + 1);
    return WeightW'($urandom_range(cap, 1));
  endfunction

  function automatic void flag_field(input string name, input int unsigned want,
                                     input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic check_result(input out_item_t got);
    out_item_t want;
    results_seen++;
    if (pending_placements.size() == 0) begin
      $display("%0t: result with nothing outstanding: expected none, actual %h", $time, got);
      mismatches++;
    end else begin
      want = pending_placements.pop_front();
      flag_field("bin_number", want.bin_number, got.bin_number);
      flag_field("opened_new", want.opened_new, got.opened_new);
      flag_field("total_bins", want.total_bins, got.total_bins);
      flag_field("status", want.status, got.status);
    end
  endtask

  // one apb transfer, setup then access; ends in the cycle after completion
  task automatic apb_xfer(input logic wr, input reg_idx_e idx,
                          input logic [ApbDataW-1:0] wdata,
                          output logic [ApbDataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic read_reg_check(input reg_idx_e idx, input logic [ApbDataW-1:0] want);
    logic [ApbDataW-1:0] readback;
    apb_xfer(1'b0, idx, '0, readback);
    if (readback !== want) begin
      $display("%0t: register %s readback: expected %0d, actual %0d",
               $time, idx.name(), want, readback);
      mismatches++;
    end
  endtask

  task automatic write_reg(input reg_idx_e idx, input int unsigned value);
    logic [ApbDataW-1:0] unused;
    apb_xfer(1'b1, idx, ApbDataW'(value), unused);
    if (idx == REG_CAPACITY) cap_reg = CapW'(value);
    else preclosed_reg = PreclosedW'(value);
    read_reg_check(idx, ApbDataW'(value));
  endtask

  // offer one item, wait for the handshake, then log what it should produce;
  // valid is left high so a following item can go straight out
  task automatic put_item(input logic [WeightW-1:0] w, input logic first,
                          input logic typed = 1'b0, input out_item_t want = '0);
    out_item_t   predicted;
    int unsigned gap;
    if (!steady_feed && burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap        = $urandom_range(6, 0);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left != 0) burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= {w, first};
    do @(posedge clk_i); while (!in_ready_o);
    predicted = place_best_fit({w, first});
    status_seen[predicted.status]++;
    if (w != '0) items_sent++;
    pending_placements.push_back(typed ? want : predicted);
  endtask

  // hold the sender back until every owed result is in
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_placements.size() != 0);
  endtask

  // open every bin full to the brim, then knock on the full table
  task automatic fill_table();
    int unsigned k;
    put_item(cap_reg, 1'b1);
    for (k = 1; k < MaxBins; k++) put_item(cap_reg, 1'b0);
    for (k = 0; k < 6; k++) put_item(WeightW'($urandom_range(cap_reg, 1)), 1'b0);
    // skip and a random pick on a full table, then a fresh start
    put_item('0, 1'b0);
    put_item(pick_weight(), 1'b0);
    put_item(WeightW'($urandom_range(cap_reg, 1)), 1'b1);
  endtask

  // packing runs, each opened by a first item, with stray first flags as noise
  task automatic pack_runs();
    int unsigned runs;
    int unsigned len;
    int unsigned r;
    int unsigned k;
    runs = $urandom_range(8, 3);
    for (r = 0; r < runs; r++) begin
      len = $urandom_range(50, 4);
      put_item(pick_weight(), 1'b1);
      for (k = 0; k < len; k++) put_item(pick_weight(), $urandom_range(49) == 0);
      if ($urandom_range(3) == 0) drain_results();
    end
  endtask

  // receiver: checks each result and stalls in styles that change over time
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_result(out_data_o);
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(3));
      rx_mode_left = $urandom_range(400, 50);
    end else begin
      rx_mode_left--;
    end
    rx_tick++;
    if (rx_hold != 0) begin
      rx_hold--;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:     out_ready_i <= 1'b1;
        RX_COIN:     out_ready_i <= 1'($urandom_range(1));
        RX_PERIODIC: out_ready_i <= (rx_tick % 3 == 0);
        default: begin
          if ($urandom_range(7) == 0) begin
            rx_hold = $urandom_range(20, 5);
            out_ready_i <= 1'b0;
          end else begin
            out_ready_i <= 1'b1;
          end
        end
      endcase
    end
  end

  // watchdog on cycles where neither channel moves an item
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("%0t: no item moved for %0d cycles", $time, StallLimit);
      $display("** best_fit_bin_packer_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned cap_pick;
    int unsigned pre_pick;
    logic        filling;

    // directed walk from the reset settings (capacity 100, nothing preclosed)
    directed_rows = '{
      {16'd0,     1'b0, 1'b1, 9'd0, 1'b0, 11'd0, ST_SKIPPED},   // zero weight straight after reset
      {16'd100,   1'b0, 1'b1, 9'd1, 1'b1, 11'd1, ST_PLACED},    // weight equal to capacity
      {16'd101,   1'b0, 1'b1, 9'd0, 1'b0, 11'd1, ST_OVER_CAP},  // just over capacity
      {16'hFFFF,  1'b0, 1'b1, 9'd0, 1'b0, 11'd1, ST_OVER_CAP},  // largest weight
      {16'd1,     1'b0, 1'b0, Untyped},                         // no room, second bin
      {16'd60,    1'b0, 1'b0, Untyped},
      {16'd40,    1'b0, 1'b0, Untyped},                         // misses by one, third bin
      {16'd39,    1'b0, 1'b0, Untyped},                         // exact fit beats a looser one
      {16'd30,    1'b0, 1'b0, Untyped},
      {16'd70,    1'b0, 1'b0, Untyped},                         // two bins now level
      {16'd10,    1'b0, 1'b0, Untyped},                         // tie goes to the lower bin
      {16'd20,    1'b0, 1'b0, Untyped},
      {16'd0,     1'b1, 1'b1, 9'd0, 1'b0, 11'd0, ST_SKIPPED},   // clear then skip
      {16'd50,    1'b0, 1'b0, Untyped},
      {16'd200,   1'b1, 1'b1, 9'd0, 1'b0, 11'd0, ST_OVER_CAP},  // clear then reject
      {16'd50,    1'b1, 1'b1, 9'd1, 1'b1, 11'd1, ST_PLACED},    // clear then place
      {16'd50,    1'b0, 1'b1, 9'd1, 1'b0, 11'd1, ST_PLACED},    // tops up the only bin
      {16'd1,     1'b0, 1'b0, Untyped},
      {16'hFFFF,  1'b1, 1'b1, 9'd0, 1'b0, 11'd0, ST_OVER_CAP},
      {16'd100,   1'b1, 1'b1, 9'd1, 1'b1, 11'd1, ST_PLACED}
    };

    // apply reset, then confirm the reset register values
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    read_reg_check(REG_CAPACITY, ApbDataW'(CapacityRst));
    read_reg_check(REG_PRECLOSED, '0);

    for (n = 0; n < NumDirected; n++) begin
      put_item(directed_rows[n].item.weight, directed_rows[n].item.first_item,
               directed_rows[n].typed, directed_rows[n].want);
    end

    // random phases, each under fresh settings written while the block is idle;
    // two phases fill the whole table, the first at the smallest capacity
    phase = 0;
    while (items_sent < ItemTarget || phase < 6) begin
      drain_results();
      filling = 1'b0;
      case (phase)
        0: begin
          cap_pick = 65535;
          pre_pick = 0;
        end
        1: begin
          cap_pick = 1;
          pre_pick = 1023;
          filling  = 1'b1;
        end
        2: begin
          cap_pick = 1;
          pre_pick = $urandom_range(1023);
        end
        4: begin
          cap_pick = 65535;
          pre_pick = 1023;
          filling  = 1'b1;
        end
        default: begin
          case ($urandom_range(2))
            0:       cap_pick = $urandom_range(40, 2);
            1:       cap_pick = $urandom_range(1000, 41);
            default: cap_pick = $urandom_range(65535, 1001);
          endcase
          pre_pick = $urandom_range(1023);
        end
      endcase
      write_reg(REG_CAPACITY, cap_pick);
      write_reg(REG_PRECLOSED, pre_pick);
      setting_count++;
      // some phases feed back to back
      steady_feed = ($urandom_range(3) == 0);
      if (filling) fill_table();
      else pack_runs();
      phase++;
    end

    // wind down: everything owed, then a full scan's worth of quiet
    drain_results();
    repeat (MaxBins + 8) @(posedge clk_i);
    if (pending_placements.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_placements.size());
      mismatches += pending_placements.size();
    end

    $display("%0d weighted items (%0d directed rows), %0d results, %0d settings",
             items_sent, NumDirected, results_seen, setting_count);
    $display("placed %0d, skipped %0d, over capacity %0d, table full %0d",
             status_seen[ST_PLACED], status_seen[ST_SKIPPED],
             status_seen[ST_OVER_CAP], status_seen[ST_TABLE_FULL]);
    if (mismatches == 0) begin
      $display("** best_fit_bin_packer_unit: PASSED **");
    end else begin
      $display("** best_fit_bin_packer_unit: FAILED **");
    end
    $finish;
  end

endmodule
